// ===== hdl/well512_pkg.sv =====
package well512_pkg;

  // Item codes; code 3 carries no meaning and is ignored
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_INT  = 2'd1,
    ACT_FRAC = 2'd2
  } action_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned OUT_W   = 53;
  localparam int unsigned LOW_W   = 21;

  localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
  localparam logic [IDX_W-1:0]  TAP_M1      = 4'd13;
  localparam logic [IDX_W-1:0]  TAP_M2      = 4'd9;

endpackage

// ===== hdl/well512a_generator.sv =====
// Integer draw: one advance, busy until it ends; the result strobe is set in its first
// write-back step. Fraction draw: two advances, strobe set in the first write-back step of the second.
// Load: one write. Each advance is four steps on one state memory with two read ports and
// one write port: two read pairs, then two write-backs (pool[i], then pool[i-1]).
// Reset clears the index and the control state; the pool memory is not cleared.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
module well512a_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_seed_position,
  input  logic [31:0] in_seed_word,
  output logic        out_valid,
  output logic [52:0] out_random_bits
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_B,
    ST_W0,
    ST_W1
  } state_t;

  localparam int unsigned WW = well512_pkg::WORD_W;
  localparam int unsigned IW = well512_pkg::IDX_W;
  localparam int unsigned LW = well512_pkg::LOW_W;

  state_t        state_r;
  logic [IW-1:0] pos_r;
  logic          frac_r;
  logic          pass_r;
  logic [WW-1:0] b_r;
  logic [WW-1:0] res_r;
  logic [WW-1:0] hi_r;
  logic          out_valid_r;
  logic [52:0]   out_bits_r;

  // state memory
  logic [WW-1:0] pool_mem [16];
  logic [IW-1:0] rd_addr0, rd_addr1;
  logic [WW-1:0] rd_data0_r, rd_data1_r;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  logic          accept;
  logic [WW-1:0] c_mix, new_a, d_val, res_nxt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // read addresses: pool[i], pool[i+13] first, then pool[i+9], pool[i-1]
  always_comb begin
    if (state_r == ST_B) begin
      rd_addr0 = pos_r + well512_pkg::TAP_M2;
      rd_addr1 = pos_r - 4'd1;
    end else begin
      rd_addr0 = pos_r;
      rd_addr1 = pos_r + well512_pkg::TAP_M1;
    end
  end

  // advance datapath, second half (data of the B-step reads)
  always_comb begin
    c_mix   = rd_data0_r ^ (rd_data0_r >> 11);
    new_a   = b_r ^ c_mix;
    d_val   = new_a ^ ((new_a << 5) & well512_pkg::TEMPER_MASK);
    res_nxt = rd_data1_r ^ b_r ^ d_val ^ (rd_data1_r << 2) ^ (b_r << 18) ^ (c_mix << 28);
  end

  // single write port: seed load, then pool[i], then pool[i-1]
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = new_a;
    priority if (accept && (in_action == well512_pkg::ACT_LOAD)) begin
      wr_en   = 1'b1;
      wr_addr = in_seed_position;
      wr_data = in_seed_word;
    end else if (state_r == ST_W0) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = new_a;
    end else if (state_r == ST_W1) begin
      wr_en   = 1'b1;
      wr_addr = pos_r - 4'd1;
      wr_data = res_r;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[wr_addr] <= wr_data;
    end
    rd_data0_r <= pool_mem[rd_addr0];
    rd_data1_r <= pool_mem[rd_addr1];
  end

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      frac_r      <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && ((in_action == well512_pkg::ACT_INT) ||
                         (in_action == well512_pkg::ACT_FRAC))) begin
            frac_r  <= (in_action == well512_pkg::ACT_FRAC);
            pass_r  <= 1'b0;
            state_r <= ST_B;
          end
        end
        ST_RD: begin
          state_r <= ST_B;
        end
        ST_B: begin
          // b from pool[i] and pool[i+13]
          b_r     <= rd_data0_r ^ rd_data1_r ^ (rd_data0_r << 16) ^ (rd_data1_r << 15);
          state_r <= ST_W0;
        end
        ST_W0: begin
          res_r <= res_nxt;
          if (!frac_r) begin
            out_valid_r <= 1'b1;
            out_bits_r  <= {21'd0, res_nxt};
          end else if (pass_r) begin
            out_valid_r <= 1'b1;
            out_bits_r  <= {hi_r, res_nxt[LW-1:0]};
          end else begin
            hi_r <= res_nxt;
          end
          state_r <= ST_W1;
        end
        ST_W1: begin
          pos_r <= pos_r - 4'd1;
          if (frac_r && !pass_r) begin
            pass_r  <= 1'b1;
            state_r <= ST_RD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_bits = out_bits_r;

  // checks
  a_strobe_after_w0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_W0))
    else $error("result strobe not preceded by write-back step");

  a_pos_moves_in_w1: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(pos_r) |-> $past(state_r == ST_W1))
    else $error("index changed outside second write-back");

  a_int_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == well512_pkg::ACT_INT)) |-> ##3 out_valid_r)
    else $error("integer draw result missing");

  a_frac_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == well512_pkg::ACT_FRAC)) |-> ##7 out_valid_r)
    else $error("fraction draw result missing");

  a_frac_single: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == well512_pkg::ACT_FRAC)) |-> ##3 !out_valid_r)
    else $error("fraction draw emitted after first advance");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Code 3 carries no operation; the block must drop it without a trace
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = well512_pkg::ACT_LOAD;
  logic [3:0]  in_seed_position = '0;
  logic [31:0] in_seed_word = '0;
  logic        out_valid;
  logic [52:0] out_random_bits;

  // Generator copy kept alongside the block
  logic [31:0] gen_pool [16];
  logic [3:0]  gen_index;
  logic [52:0] pending_draws [$];
  logic [52:0] want_bits;
  int          error_count = 0;
  int          stall_cycles = 0;
  int          idle_pct = 0;

  well512a_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_seed_position (in_seed_position),
    .in_seed_word     (in_seed_word),
    .out_valid        (out_valid),
    .out_random_bits  (out_random_bits)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // One WELL512a step: rewrites pool[i] and pool[i-1], returns the new pool[i-1]
  function automatic logic [31:0] next_word();
    logic [3:0]  i;
    logic [3:0]  j;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    i = gen_index;
    j = i + well512_pkg::TAP_M1;
    a = gen_pool[i];
    c = gen_pool[j];
    b = a ^ c ^ (a << 16) ^ (c << 15);
    j = i + well512_pkg::TAP_M2;
    c = gen_pool[j];
    c = c ^ (c >> 11);
    a = b ^ c;
    gen_pool[i] = a;
    d = a ^ ((a << 5) & well512_pkg::TEMPER_MASK);
    i = i - 4'd1;
    gen_index = i;
    a = gen_pool[i];
    gen_pool[i] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
    return gen_pool[i];
  endfunction

  // Seed words lean toward the all-zero and all-one extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Drive one item, hold it until the transfer, then update the prediction.
  // start is left high so a following item can go out back to back.
  task automatic send_item(logic [1:0] act, logic [3:0] pos, logic [31:0] word);
    logic [31:0] hi;
    logic [31:0] lo;
    start            <= 1'b1;
    in_action        <= act;
    in_seed_position <= pos;
    in_seed_word     <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (act)
      well512_pkg::ACT_LOAD: gen_pool[pos] = word;
      well512_pkg::ACT_INT: pending_draws.push_back({21'd0, next_word()});
      well512_pkg::ACT_FRAC: begin
        hi = next_word();
        lo = next_word();
        pending_draws.push_back({hi, lo[well512_pkg::LOW_W-1:0]});
      end
      default: ;
    endcase
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(1, 100) <= idle_pct) idle_cycles($urandom_range(1, 12));
  endtask

  task automatic send_draw(logic [1:0] act);
    send_item(act, 4'($urandom_range(0, 15)), $urandom);
  endtask

  // Full seed, so every later read hits a written word
  task automatic reseed_all();
    for (int k = 0; k < 16; k++) begin
      send_item(well512_pkg::ACT_LOAD, 4'(k), pick_word());
      maybe_idle();
    end
  endtask

  // Extremes of the seed fields, both draw kinds, the unused code, reseeding mid-stream
  task automatic test_directed();
    for (int k = 0; k < 16; k++) begin
      case (k)
        0: send_item(well512_pkg::ACT_LOAD, 4'(k), 32'h0000_0000);
        5: send_item(well512_pkg::ACT_LOAD, 4'(k), 32'h8000_0001);
        15: send_item(well512_pkg::ACT_LOAD, 4'(k), 32'hFFFF_FFFF);
        default: send_item(well512_pkg::ACT_LOAD, 4'(k), $urandom);
      endcase
    end
    send_item(well512_pkg::ACT_INT, 4'd0, 32'h0000_0000);
    send_item(well512_pkg::ACT_FRAC, 4'd15, 32'hFFFF_FFFF);
    send_item(ACT_UNUSED, 4'd15, 32'hFFFF_FFFF);
    send_item(well512_pkg::ACT_INT, 4'd15, 32'hFFFF_FFFF);
    send_item(well512_pkg::ACT_LOAD, 4'd9, 32'h0000_0000);
    send_item(well512_pkg::ACT_FRAC, 4'd0, 32'h0000_0000);
    send_item(well512_pkg::ACT_LOAD, 4'd13, 32'hFFFF_FFFF);
    send_item(well512_pkg::ACT_INT, 4'd7, 32'h5A5A_A5A5);
    send_item(well512_pkg::ACT_FRAC, 4'd8, 32'hA5A5_5A5A);
  endtask

  // Mostly draws on a seeded pool, with reseeds, single loads and unused codes
  task automatic test_random_mix(int n_items);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 50 == 0) idle_pct = 20 * $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        reseed_all();
        sent += 16;
      end else if (roll < 16) begin
        send_item(well512_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), pick_word());
        sent++;
      end else if (roll < 22) begin
        send_item(ACT_UNUSED, 4'($urandom_range(0, 15)), $urandom);
      end else if (roll < 61) begin
        send_draw(well512_pkg::ACT_INT);
        sent++;
      end else begin
        send_draw(well512_pkg::ACT_FRAC);
        sent++;
      end
      maybe_idle();
    end
  endtask

  // Sender holds off until every outstanding draw has come back
  task automatic test_drain_pause();
    idle_pct = 0;
    send_draw(well512_pkg::ACT_FRAC);
    send_draw(well512_pkg::ACT_INT);
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    send_draw(well512_pkg::ACT_INT);
    send_item(well512_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), pick_word());
    send_draw(well512_pkg::ACT_FRAC);
  endtask

  // Closing stretch: back-to-back transfers only
  task automatic test_steady_stream(int n_items);
    idle_pct = 0;
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 9))
        0: send_item(well512_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), pick_word());
        1, 2, 3, 4: send_draw(well512_pkg::ACT_INT);
        default: send_draw(well512_pkg::ACT_FRAC);
      endcase
    end
  endtask

  // Result checker: the block cannot be stalled, so every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("result %h with no draw pending", out_random_bits));
      end else begin
        want_bits = pending_draws.pop_front();
        if (out_random_bits !== want_bits)
          report_mismatch($sformatf("random_bits got %h want %h", out_random_bits, want_bits));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("well512a_generator test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < 16; k++) gen_pool[k] = '0;
    gen_index = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(560);
    test_drain_pause();
    test_steady_stream(150);
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("well512a_generator test passed");
    end else begin
      $display("well512a_generator test failed");
    end
    $finish;
  end

endmodule
